FILE: rtl/fixed_point_square_root_top_macros.svh
// assertion macros for the square root block
// used by the port checker; no other dependencies
`ifndef FIXED_POINT_SQUARE_ROOT_TOP_MACROS_SVH
`define FIXED_POINT_SQUARE_ROOT_TOP_MACROS_SVH

// property checked only while out of reset
`define FPSQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define FPSQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/fpsqrt_pkg.sv
// shared types, constants and seed function for the square root block
// no dependencies
package fpsqrt_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 29;
    localparam int NUM_BITS  = DATA_W + FRAC_BITS;
    localparam int STEPS     = 7;
    // cells per newton step: one per quotient bit plus the update cell
    localparam int STEP_LEN  = NUM_BITS + 1;
    localparam int CHAIN_LEN = STEPS * STEP_LEN;

    // data carried from cell to cell
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] rad;
        logic [DATA_W-1:0] est;
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] quo;
    } t_cell;

    // initial estimate built from the radicand bits
    function automatic logic [DATA_W-1:0] seed_of(input logic [DATA_W-1:0] r);
        logic [DATA_W-1:0] e;
        begin
            e = r | (DATA_W'(1) << 15);
            e = e | ({24'd0, r[7:0]} << 11);
            e = e | ({16'd0, r[15:0]} << 7);
            e = e | ({8'd0, r[23:0]} << 3);
            e = e | ({4'd0, r[27:0]} << 1);
            return e;
        end
    endfunction

endpackage

FILE: rtl/fpsqrt_div_cell.sv
// one restoring division cell: produces one quotient bit per item
// depends on fpsqrt_pkg
module fpsqrt_div_cell
    import fpsqrt_pkg::*;
#(
    parameter int BIT_POS = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  t_cell i_d,
    output t_cell o_q
);

    logic        w_din;
    logic [32:0] w_sh;
    logic [32:0] w_diff;
    logic        w_ge;
    t_cell       n_q;
    t_cell       r_q;

    // dividend bit: radicand shifted up by the fraction width
    generate
        if (BIT_POS >= FRAC_BITS) begin : g_rad_bit
            assign w_din = i_d.rad[BIT_POS-FRAC_BITS];
        end else begin : g_zero_bit
            assign w_din = 1'b0;
        end
    endgenerate

    // shift, compare and conditionally subtract
    always_comb begin
        w_sh      = {i_d.rem, w_din};
        w_diff    = w_sh - {1'b0, i_d.est};
        w_ge      = (w_sh >= {1'b0, i_d.est});
        n_q       = i_d;
        n_q.rem   = w_ge ? w_diff[31:0] : w_sh[31:0];
        n_q.quo   = {i_d.quo[30:0], w_ge};
    end

    // cell register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else if (i_adv) begin
            r_q.valid <= n_q.valid;
        end
        if (i_adv) begin
            r_q.rad <= n_q.rad;
            r_q.est <= n_q.est;
            r_q.rem <= n_q.rem;
            r_q.quo <= n_q.quo;
        end
    end

    assign o_q = r_q;

endmodule

FILE: rtl/fpsqrt_upd_cell.sv
// newton update cell: estimate plus quotient, halved
// depends on fpsqrt_pkg
module fpsqrt_upd_cell
    import fpsqrt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  t_cell i_d,
    output t_cell o_q
);

    logic [DATA_W-1:0] w_sum;
    t_cell             n_q;
    t_cell             r_q;

    // wrapping sum, halve, clear division state for the next step
    always_comb begin
        w_sum     = i_d.est + i_d.quo;
        n_q       = i_d;
        n_q.est   = {1'b0, w_sum[DATA_W-1:1]};
        n_q.rem   = '0;
        n_q.quo   = '0;
    end

    // cell register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else if (i_adv) begin
            r_q.valid <= n_q.valid;
        end
        if (i_adv) begin
            r_q.rad <= n_q.rad;
            r_q.est <= n_q.est;
            r_q.rem <= n_q.rem;
            r_q.quo <= n_q.quo;
        end
    end

    assign o_q = r_q;

endmodule

FILE: rtl/fixed_point_square_root_top.sv
// channel    | dir | handshake                 | payload
// input      | in  | i_in_valid / o_in_stall   | i_radicand[31:0]
// output     | out | o_out_valid / i_out_stall | o_root[31:0]
//
// one item per cycle while the output is not stalled; seed register, then 7 newton steps
// of 61 division cells (one quotient bit each) and one update cell
// synchronous active-low reset clears the valid bit of every cell
// a stalled result freezes the whole chain and stalls the input
// depends on fpsqrt_pkg, fpsqrt_div_cell, fpsqrt_upd_cell
module fixed_point_square_root_top
    import fpsqrt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic [31:0] i_radicand,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output logic [31:0] o_root,
    input  logic        i_out_stall
);

    t_cell w_chain [0:CHAIN_LEN];
    t_cell r_seed;
    logic  w_adv;

    // chain moves unless a finished item is held at the output
    assign w_adv      = !(w_chain[CHAIN_LEN].valid && i_out_stall);
    assign o_in_stall = !w_adv;

    // seed register at the head of the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed.valid <= 1'b0;
        end else if (w_adv) begin
            r_seed.valid <= i_in_valid;
        end
        if (w_adv) begin
            r_seed.rad <= i_radicand;
            r_seed.est <= seed_of(i_radicand);
            r_seed.rem <= '0;
            r_seed.quo <= '0;
        end
    end

    assign w_chain[0] = r_seed;

    // row of cells: per step, division bits from the top down, then update
    generate
        for (genvar s = 0; s < STEPS; s++) begin : g_step
            for (genvar b = 0; b < NUM_BITS; b++) begin : g_bit
                fpsqrt_div_cell #(
                    .BIT_POS (NUM_BITS - 1 - b)
                ) u_div (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_adv   (w_adv),
                    .i_d     (w_chain[s*STEP_LEN + b]),
                    .o_q     (w_chain[s*STEP_LEN + b + 1])
                );
            end
            fpsqrt_upd_cell u_upd (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (w_adv),
                .i_d     (w_chain[s*STEP_LEN + NUM_BITS]),
                .o_q     (w_chain[s*STEP_LEN + NUM_BITS + 1])
            );
        end
    endgenerate

    // last update cell is the output register
    assign o_out_valid = w_chain[CHAIN_LEN].valid;
    assign o_root      = w_chain[CHAIN_LEN].est;

endmodule

FILE: rtl/fpsqrt_checker.sv
// port-level checker for the square root block, bound to the top level
// depends on fixed_point_square_root_top_macros.svh
`include "fixed_point_square_root_top_macros.svh"

module fpsqrt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic [31:0] i_radicand,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic [31:0] o_root,
    input logic        i_out_stall
);

    // a held result stays offered
    `FPSQ_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid, "result dropped while stalled")
    // a held result keeps its value
    `FPSQ_ASSERT(a_root_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> $stable(o_root), "root changed while stalled")
    // input stalls exactly when a result is held back
    `FPSQ_ASSERT(a_stall_link, i_clk, i_rst_n, o_in_stall == (o_out_valid && i_out_stall), "input stall not tied to output hold")
    // reset empties the output
    `FPSQ_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

bind fixed_point_square_root_top fpsqrt_checker u_fpsqrt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_radicand  (i_radicand),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_root      (o_root),
    .i_out_stall (i_out_stall)
);
